// ----- hdl/prrs_pkg.sv -----
// Shared constants for the priority round-robin scheduler.
package prrs_pkg;

   localparam int MAX_TASKS_DEF = 64;
   localparam int LEVELS_DEF = 4;

   localparam int SLICE_REGS = 4;
   localparam logic [7:0] SLICE_RESET [SLICE_REGS] = '{8'd8, 8'd12, 8'd16, 8'd20};

   localparam logic [2:0] ACT_ADD = 3'd0;
   localparam logic [2:0] ACT_REMOVE = 3'd1;
   localparam logic [2:0] ACT_SETPRI = 3'd2;
   localparam logic [2:0] ACT_SETRUN = 3'd3;
   localparam logic [2:0] ACT_SCHED = 3'd4;
   localparam logic [2:0] ACT_QUERY = 3'd5;

endpackage

// ----- hdl/priority_round_robin_scheduler.sv -----
// Multilevel priority round-robin scheduler: queues, task tables and sequencer.
// One word is processed at a time by a small sequencer over memories with one write port
// and registered reads. After reset a clearing pass steps through all
// 2**(clog2(MAX_TASKS)+clog2(LEVELS)) addresses (256 by default) and zeroes the task
// tables before the first word is taken. Remove scans its task's queue and shifts the
// entries behind the task forward; set priority does the same and then appends the task
// to its new level, and add appends, or is refused when the queue is full. Schedule walks
// the queues from the highest level down and picks the first runnable task; a task whose
// slice is used up is moved to the back of its queue and its rotation count goes up.
// The sequencer holds its last state while the previous result waits to be taken; the next
// word is accepted once it is back to idle.
module priority_round_robin_scheduler #(
   parameter int MAX_TASKS = prrs_pkg::MAX_TASKS_DEF,
   parameter int LEVELS = prrs_pkg::LEVELS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // action[2:0], task_id[8:3], priority_req[10:9], runnable[11], level[13:12]
   input  logic [15:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // ok[0], chosen_id[6:1], task_priority[8:7], tick_count[16:9], rotation_count[32:17]
   output logic [39:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   localparam int IDW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int LVW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int CW = $clog2(MAX_TASKS + 1);
   localparam int QAW = LVW + IDW;

   typedef enum logic [13:0] {
      S_CLEAR  = 14'd1 << 0,
      S_IDLE   = 14'd1 << 1,
      S_RM_LVL = 14'd1 << 2,
      S_RM_RD  = 14'd1 << 3,
      S_RM_CHK = 14'd1 << 4,
      S_SH_RD  = 14'd1 << 5,
      S_SH_WR  = 14'd1 << 6,
      S_APPEND = 14'd1 << 7,
      S_AP_ROT = 14'd1 << 8,
      S_SC_RD  = 14'd1 << 9,
      S_SC_T   = 14'd1 << 10,
      S_SC_CHK = 14'd1 << 11,
      S_Q_WAIT = 14'd1 << 12,
      S_DONE   = 14'd1 << 13
   } state_type;

   state_type state_ff;
   logic [QAW-1:0] clr_ff;
   logic [7:0] slice_ff [prrs_pkg::SLICE_REGS];
   logic [CW-1:0] fill_ff [LEVELS];
   logic [2:0] op_ff;
   logic [IDW-1:0] id_ff;
   logic [LVW-1:0] pri_ff;
   logic [LVW-1:0] cur_ff;
   logic [CW-1:0] idx_ff;
   logic res_ok_ff;
   logic [IDW-1:0] res_chosen_ff;
   logic [LVW-1:0] res_prio_ff;
   logic [7:0] res_tick_ff;
   logic [15:0] res_rot_ff;
   logic rsp_tvalid_ff;
   logic [39:0] rsp_tdata_ff;

   logic q_we, t_we, r_we, l_we, y_we;
   logic [QAW-1:0] q_waddr, q_raddr, t_waddr, t_raddr, r_waddr, r_raddr;
   logic [IDW-1:0] q_wdata, q_rdata, l_waddr, l_raddr, y_waddr, y_raddr;
   logic [7:0] t_wdata, t_rdata;
   logic [15:0] r_wdata, r_rdata;
   logic [LVW-1:0] l_wdata, l_rdata;
   logic y_wdata, y_rdata;

   logic [2:0] in_act;
   logic [5:0] in_id;
   logic [1:0] in_pri;
   logic in_run;
   logic [1:0] in_lvl;
   logic id_ok, pri_ok, lvl_ok, accept;
   logic [CW-1:0] fill_cur, idx_next;
   logic [7:0] slice_cur;
   logic [2:0] cur_ext;
   logic [15:0] rot_inc;

   assign in_act = req_tdata[2:0];
   assign in_id = req_tdata[8:3];
   assign in_pri = req_tdata[10:9];
   assign in_run = req_tdata[11];
   assign in_lvl = req_tdata[13:12];
   assign id_ok = 32'(in_id) < MAX_TASKS;
   assign pri_ok = 32'(in_pri) < LEVELS;
   assign lvl_ok = 32'(in_lvl) < LEVELS;
   assign req_tready = (state_ff == S_IDLE);
   assign accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata = rsp_tdata_ff;

   assign fill_cur = fill_ff[cur_ff];
   assign idx_next = idx_ff + 1'b1;
   assign cur_ext = 3'(cur_ff);
   assign slice_cur = (cur_ext < 3'd4) ? slice_ff[cur_ext[1:0]] : 8'd0;
   assign rot_inc = (r_rdata == 16'hFFFF) ? r_rdata : r_rdata + 16'd1;

   always_comb begin
      q_we = 1'b0; q_waddr = {cur_ff, idx_ff[IDW-1:0]}; q_wdata = q_rdata;
      q_raddr = {cur_ff, idx_ff[IDW-1:0]};
      t_we = 1'b0; t_waddr = {id_ff, cur_ff}; t_wdata = 8'd0; t_raddr = {id_ff, cur_ff};
      r_we = 1'b0; r_waddr = {id_ff, cur_ff}; r_wdata = rot_inc; r_raddr = {id_ff, cur_ff};
      l_we = 1'b0; l_waddr = id_ff; l_wdata = cur_ff; l_raddr = id_ff;
      y_we = 1'b0; y_waddr = id_ff; y_wdata = 1'b0; y_raddr = id_ff;
      case (state_ff)
         S_CLEAR: begin
            t_we = 1'b1; t_waddr = clr_ff;
            r_we = 1'b1; r_waddr = clr_ff; r_wdata = 16'd0;
            l_we = 1'b1; l_waddr = clr_ff[IDW-1:0]; l_wdata = '0;
            y_we = 1'b1; y_waddr = clr_ff[IDW-1:0];
         end
         S_IDLE: begin
            l_raddr = IDW'(in_id);
            t_raddr = {IDW'(in_id), LVW'(in_lvl)};
            r_raddr = {IDW'(in_id), LVW'(in_lvl)};
            y_waddr = IDW'(in_id);
            y_wdata = in_run;
            y_we = accept && (in_act == prrs_pkg::ACT_SETRUN) && id_ok;
         end
         S_SH_RD: begin
            q_raddr = {cur_ff, idx_next[IDW-1:0]};
         end
         S_SH_WR: begin
            q_we = 1'b1;
         end
         S_APPEND: begin
            q_waddr = {cur_ff, fill_cur[IDW-1:0]};
            q_wdata = id_ff;
            q_we = 32'(fill_cur) < MAX_TASKS;
            l_we = q_we;
         end
         S_AP_ROT: begin
            r_we = 1'b1;
         end
         S_SC_T: begin
            y_raddr = q_rdata;
            t_raddr = {q_rdata, cur_ff};
            r_raddr = {q_rdata, cur_ff};
         end
         S_SC_CHK: begin
            t_we = y_rdata;
            t_wdata = (t_rdata == slice_cur) ? 8'd0 : t_rdata + 8'd1;
         end
         default: begin
         end
      endcase
   end

   prrs_ram #(.W(IDW), .AW(QAW)) u_queue (
      .clock(clock), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
      .raddr(q_raddr), .rdata(q_rdata));
   prrs_ram #(.W(8), .AW(QAW)) u_ticks (
      .clock(clock), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
      .raddr(t_raddr), .rdata(t_rdata));
   prrs_ram #(.W(16), .AW(QAW)) u_rots (
      .clock(clock), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
      .raddr(r_raddr), .rdata(r_rdata));
   prrs_ram #(.W(LVW), .AW(IDW)) u_level (
      .clock(clock), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
      .raddr(l_raddr), .rdata(l_rdata));
   prrs_ram #(.W(1), .AW(IDW)) u_ready (
      .clock(clock), .we(y_we), .waddr(y_waddr), .wdata(y_wdata),
      .raddr(y_raddr), .rdata(y_rdata));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         cur_ff <= '0;
         idx_ff <= '0;
         rsp_tvalid_ff <= 1'b0;
         for (int i = 0; i < prrs_pkg::SLICE_REGS; i++) begin
            slice_ff[i] <= prrs_pkg::SLICE_RESET[i];
         end
         for (int i = 0; i < LEVELS; i++) begin
            fill_ff[i] <= '0;
         end
      end else begin
         if (csr_we) begin
            slice_ff[csr_index] <= csr_wdata;
         end
         if (rsp_tvalid_ff && rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == '1) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (accept) begin
                  op_ff <= in_act;
                  id_ff <= IDW'(in_id);
                  pri_ff <= LVW'(in_pri);
                  idx_ff <= '0;
                  res_ok_ff <= 1'b0;
                  res_chosen_ff <= '0;
                  res_prio_ff <= '0;
                  res_tick_ff <= 8'd0;
                  res_rot_ff <= 16'd0;
                  state_ff <= S_DONE;
                  case (in_act)
                     prrs_pkg::ACT_ADD: begin
                        if (id_ok && pri_ok) begin
                           cur_ff <= LVW'(in_pri);
                           state_ff <= S_APPEND;
                        end
                     end
                     prrs_pkg::ACT_REMOVE: begin
                        if (id_ok) begin
                           state_ff <= S_RM_LVL;
                        end
                     end
                     prrs_pkg::ACT_SETPRI: begin
                        if (id_ok && pri_ok) begin
                           state_ff <= S_RM_LVL;
                        end
                     end
                     prrs_pkg::ACT_SETRUN: begin
                        res_ok_ff <= id_ok;
                     end
                     prrs_pkg::ACT_SCHED: begin
                        cur_ff <= LVW'(LEVELS - 1);
                        state_ff <= S_SC_RD;
                     end
                     prrs_pkg::ACT_QUERY: begin
                        if (id_ok && lvl_ok) begin
                           state_ff <= S_Q_WAIT;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            S_RM_LVL: begin
               cur_ff <= l_rdata;
               state_ff <= S_RM_RD;
            end
            S_RM_RD: begin
               if (idx_ff >= fill_cur) begin
                  if (op_ff == prrs_pkg::ACT_SETPRI) begin
                     cur_ff <= pri_ff;
                     state_ff <= S_APPEND;
                  end else begin
                     state_ff <= S_DONE;
                  end
               end else begin
                  state_ff <= S_RM_CHK;
               end
            end
            S_RM_CHK: begin
               if (q_rdata == id_ff) begin
                  state_ff <= S_SH_RD;
               end else begin
                  idx_ff <= idx_next;
                  state_ff <= S_RM_RD;
               end
            end
            S_SH_RD: begin
               if (idx_next >= fill_cur) begin
                  fill_ff[cur_ff] <= fill_cur - 1'b1;
                  if (op_ff == prrs_pkg::ACT_REMOVE) begin
                     res_ok_ff <= 1'b1;
                     state_ff <= S_DONE;
                  end else begin
                     if (op_ff == prrs_pkg::ACT_SETPRI) begin
                        cur_ff <= pri_ff;
                     end
                     state_ff <= S_APPEND;
                  end
               end else begin
                  state_ff <= S_SH_WR;
               end
            end
            S_SH_WR: begin
               idx_ff <= idx_next;
               state_ff <= S_SH_RD;
            end
            S_APPEND: begin
               if (32'(fill_cur) < MAX_TASKS) begin
                  fill_ff[cur_ff] <= fill_cur + 1'b1;
                  state_ff <= S_AP_ROT;
               end else begin
                  res_ok_ff <= 1'b0;
                  state_ff <= S_DONE;
               end
            end
            S_AP_ROT: begin
               res_ok_ff <= 1'b1;
               if (op_ff == prrs_pkg::ACT_SCHED) begin
                  res_rot_ff <= rot_inc;
               end
               state_ff <= S_DONE;
            end
            S_SC_RD: begin
               if (idx_ff >= fill_cur) begin
                  idx_ff <= '0;
                  if (cur_ff == '0) begin
                     state_ff <= S_DONE;
                  end else begin
                     cur_ff <= cur_ff - 1'b1;
                  end
               end else begin
                  state_ff <= S_SC_T;
               end
            end
            S_SC_T: begin
               id_ff <= q_rdata;
               state_ff <= S_SC_CHK;
            end
            S_SC_CHK: begin
               if (!y_rdata) begin
                  idx_ff <= idx_next;
                  state_ff <= S_SC_RD;
               end else begin
                  res_ok_ff <= 1'b1;
                  res_chosen_ff <= id_ff;
                  res_prio_ff <= cur_ff;
                  if (t_rdata == slice_cur) begin
                     res_tick_ff <= 8'd0;
                     state_ff <= S_SH_RD;
                  end else begin
                     res_tick_ff <= t_rdata + 8'd1;
                     res_rot_ff <= r_rdata;
                     state_ff <= S_DONE;
                  end
               end
            end
            S_Q_WAIT: begin
               res_ok_ff <= 1'b1;
               res_prio_ff <= l_rdata;
               res_tick_ff <= t_rdata;
               res_rot_ff <= r_rdata;
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_tdata_ff <= {7'd0, res_rot_ff, res_tick_ff, 2'(res_prio_ff),
                                   6'(res_chosen_ff), res_ok_ff};
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      32'(fill_cur) <= MAX_TASKS)
      else $error("queue fill count beyond capacity");
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req_tready)
      else $error("word accepted during clearing pass");
   a_rotate_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_APPEND && op_ff == prrs_pkg::ACT_SCHED) |-> 32'(fill_cur) < MAX_TASKS)
      else $error("rotation found its queue full");
   a_result_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && !rsp_tvalid_ff) |=> rsp_tvalid_ff)
      else $error("result not presented after completion");
`endif

endmodule

// ----- hdl/prrs_ram.sv -----
// Single-port-write, registered-read memory used for the queue and task tables.
module prrs_ram #(
   parameter int W = 8,
   parameter int AW = 8
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [W-1:0]  wdata,
   input  logic [AW-1:0] raddr,
   output logic [W-1:0]  rdata
);

   logic [W-1:0] mem [2**AW];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ----- verif/priority_round_robin_scheduler_tb.sv -----
// Self-checking testbench for the priority round-robin scheduler, with a built-in predictor.
`timescale 1ns / 1ps

module priority_round_robin_scheduler_tb;

   localparam int NTASK = 64;
   localparam int NLVL = 4;
   localparam int CYCLE_LIMIT = 10000000;
   localparam logic [2:0] ACT_BAD6 = 3'd6;
   localparam logic [2:0] ACT_BAD7 = 3'd7;
   localparam logic [1:0] CSR_SLICE_L0 = 2'd0;
   localparam logic [1:0] CSR_SLICE_L1 = 2'd1;
   localparam logic [1:0] CSR_SLICE_L2 = 2'd2;
   localparam logic [1:0] CSR_SLICE_L3 = 2'd3;

   typedef struct packed {
      logic [15:0] rots;
      logic [7:0]  ticks;
      logic [1:0]  prio;
      logic [5:0]  chosen;
      logic        ok;
   } outcome_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [7:0]  csr_wdata = '0;

   priority_round_robin_scheduler u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   // Scheduler state mirror.
   logic [7:0]  slice_mirror [NLVL];
   logic [5:0]  queue_ids [NLVL][NTASK];
   int          queue_len [NLVL];
   logic [1:0]  level_of [NTASK];
   logic        ready_of [NTASK];
   logic [7:0]  ticks_of [NTASK][NLVL];
   logic [15:0] rots_of [NTASK][NLVL];

   logic [15:0] pending_words [$];
   outcome_type expected_outcomes [$];
   int          errors = 0;
   int          words_sent = 0;
   int          results_seen = 0;
   int          refusals_seen = 0;
   int          cycles = 0;

   function automatic bit queue_append(int lv, logic [5:0] id);
      if (queue_len[lv] >= NTASK) return 1'b0;
      queue_ids[lv][queue_len[lv]] = id;
      queue_len[lv]++;
      if (rots_of[id][lv] != 16'hFFFF) rots_of[id][lv]++;
      level_of[id] = lv[1:0];
      return 1'b1;
   endfunction

   function automatic bit queue_drop(int lv, logic [5:0] id);
      for (int i = 0; i < queue_len[lv]; i++) begin
         if (queue_ids[lv][i] == id) begin
            for (int k = i; k + 1 < queue_len[lv]; k++)
               queue_ids[lv][k] = queue_ids[lv][k + 1];
            queue_len[lv]--;
            queue_ids[lv][queue_len[lv]] = '0;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic outcome_type predict_outcome(logic [15:0] w);
      outcome_type o;
      logic [2:0] act;
      logic [5:0] id;
      logic [1:0] pri;
      logic [1:0] lvq;
      logic [5:0] t;
      bit found;
      o = '0;
      act = w[2:0];
      id = w[8:3];
      pri = w[10:9];
      lvq = w[13:12];
      found = 1'b0;
      case (act)
         prrs_pkg::ACT_ADD: o.ok = queue_append(pri, id);
         prrs_pkg::ACT_REMOVE: o.ok = queue_drop(level_of[id], id);
         prrs_pkg::ACT_SETPRI: begin
            void'(queue_drop(level_of[id], id));
            o.ok = queue_append(pri, id);
         end
         prrs_pkg::ACT_SETRUN: begin
            ready_of[id] = w[11];
            o.ok = 1'b1;
         end
         prrs_pkg::ACT_SCHED: begin
            for (int l = NLVL - 1; l >= 0 && !found; l--) begin
               for (int j = 0; j < queue_len[l] && !found; j++) begin
                  t = queue_ids[l][j];
                  if (ready_of[t]) begin
                     if (ticks_of[t][l] == slice_mirror[l]) begin
                        ticks_of[t][l] = '0;
                        void'(queue_drop(l, t));
                        void'(queue_append(l, t));
                     end else begin
                        ticks_of[t][l] = ticks_of[t][l] + 8'd1;
                     end
                     o.ok = 1'b1;
                     o.chosen = t;
                     o.prio = l[1:0];
                     o.ticks = ticks_of[t][l];
                     o.rots = rots_of[t][l];
                     found = 1'b1;
                  end
               end
            end
         end
         prrs_pkg::ACT_QUERY: begin
            o.ok = 1'b1;
            o.prio = level_of[id];
            o.ticks = ticks_of[id][lvq];
            o.rots = rots_of[id][lvq];
         end
         default: o = '0;
      endcase
      return o;
   endfunction

   function automatic logic [15:0] pack_word(logic [2:0] act, logic [5:0] id, logic [1:0] pri,
                                             logic run, logic [1:0] lv);
      return {2'b00, lv, run, pri, id, act};
   endfunction

   task automatic push_word(logic [2:0] act, logic [5:0] id, logic [1:0] pri, logic run,
                            logic [1:0] lv);
      pending_words.push_back(pack_word(act, id, pri, run, lv));
   endtask

   function automatic logic [5:0] pick_id();
      return ($urandom_range(0, 9) < 7) ? 6'($urandom_range(0, 15)) : 6'($urandom_range(0, 63));
   endfunction

   task automatic push_random(int n);
      int r;
      logic [1:0] lv;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 18)
            push_word(prrs_pkg::ACT_ADD, pick_id(), 2'($urandom), 1'($urandom), 2'($urandom));
         else if (r < 26)
            push_word(prrs_pkg::ACT_REMOVE, pick_id(), 2'($urandom), 1'($urandom),
                      2'($urandom));
         else if (r < 32)
            push_word(prrs_pkg::ACT_SETPRI, pick_id(), 2'($urandom), 1'($urandom),
                      2'($urandom));
         else if (r < 44)
            push_word(prrs_pkg::ACT_SETRUN, pick_id(), 2'($urandom),
                      1'($urandom_range(0, 3) != 0), 2'($urandom));
         else if (r < 82)
            push_word(prrs_pkg::ACT_SCHED, 6'($urandom), 2'($urandom), 1'($urandom),
                      2'($urandom));
         else if (r < 94)
            push_word(prrs_pkg::ACT_QUERY, pick_id(), 2'($urandom), 1'($urandom),
                      2'($urandom));
         else if (r < 97)
            push_word(($urandom_range(0, 1) != 0) ? ACT_BAD6 : ACT_BAD7, 6'($urandom),
                      2'($urandom), 1'($urandom), 2'($urandom));
         else if ($urandom_range(0, 2) == 0) begin
            // Overfill one level so the refusal path is taken, then schedule and move random tasks.
            lv = 2'($urandom);
            for (int k = 0; k < NTASK + 2; k++)
               push_word(prrs_pkg::ACT_ADD, 6'($urandom), lv, 1'($urandom), 2'($urandom));
            for (int k = 0; k < 4; k++) push_word(prrs_pkg::ACT_SCHED, '0, '0, 1'b0, '0);
            for (int k = 0; k < 40; k++)
               push_word(prrs_pkg::ACT_SETPRI, 6'($urandom), 2'($urandom), 1'($urandom),
                         2'($urandom));
            i += NTASK + 46;
         end else push_word(prrs_pkg::ACT_SCHED, '0, '0, 1'b0, '0);
      end
   endtask

   task automatic write_slice(logic [1:0] idx, logic [7:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      slice_mirror[idx] = val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_slices(logic [7:0] s0, logic [7:0] s1, logic [7:0] s2, logic [7:0] s3);
      write_slice(CSR_SLICE_L0, s0);
      write_slice(CSR_SLICE_L1, s1);
      write_slice(CSR_SLICE_L2, s2);
      write_slice(CSR_SLICE_L3, s3);
   endtask

   task automatic drain();
      while (pending_words.size() != 0 || req_tvalid || expected_outcomes.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Sender: bursts of words separated by random gaps.
   int burst_left = 1;
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_outcomes.push_back(predict_outcome(req_tdata));
            words_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_words.size() != 0) begin
               req_tvalid <= 1'b1;
               req_tdata <= pending_words.pop_front();
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 30);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: checks each result word and stalls on its own pattern.
   int stall_mode = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   outcome_type got, want;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[32:0];
            results_seen++;
            if (expected_outcomes.size() == 0) begin
               $display("%0t: unexpected result word %h", $time, rsp_tdata);
               errors++;
            end else begin
               want = expected_outcomes.pop_front();
               if (got.ok != want.ok || got.chosen != want.chosen || got.prio != want.prio ||
                   got.ticks != want.ticks || got.rots != want.rots) begin
                  $display("%0t: expected ok=%0d id=%0d pri=%0d ticks=%0d rots=%0d",
                           $time, want.ok, want.chosen, want.prio, want.ticks, want.rots);
                  $display("%0t: actual   ok=%0d id=%0d pri=%0d ticks=%0d rots=%0d",
                           $time, got.ok, got.chosen, got.prio, got.ticks, got.rots);
                  errors++;
               end
               if (!want.ok) refusals_seen++;
            end
            if (results_seen % 150 == 0) stall_mode = $urandom_range(0, 2);
            if (results_seen == 300 && !hold_done) begin
               hold_left = 3000;
               hold_done = 1'b1;
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (stall_mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 1) != 0);
               default: rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      for (int l = 0; l < NLVL; l++) begin
         slice_mirror[l] = prrs_pkg::SLICE_RESET[l];
         queue_len[l] = 0;
         for (int t = 0; t < NTASK; t++) begin
            queue_ids[l][t] = '0;
            ticks_of[t][l] = '0;
            rots_of[t][l] = '0;
         end
      end
      for (int t = 0; t < NTASK; t++) begin
         level_of[t] = '0;
         ready_of[t] = 1'b0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed opening: empty schedule, extremes, duplicates, absent ids, bad actions.
      push_word(prrs_pkg::ACT_SCHED, 6'd63, 2'd3, 1'b1, 2'd3);
      push_word(prrs_pkg::ACT_ADD, 6'd0, 2'd3, 1'b0, 2'd0);
      push_word(prrs_pkg::ACT_ADD, 6'd63, 2'd0, 1'b1, 2'd3);
      push_word(prrs_pkg::ACT_ADD, 6'd63, 2'd0, 1'b0, 2'd0);
      push_word(prrs_pkg::ACT_ADD, 6'd42, 2'd1, 1'b0, 2'd0);
      push_word(prrs_pkg::ACT_SCHED, '0, '0, 1'b0, '0);
      push_word(prrs_pkg::ACT_SETRUN, 6'd63, 2'd0, 1'b1, 2'd0);
      push_word(prrs_pkg::ACT_SETRUN, 6'd0, 2'd3, 1'b1, 2'd3);
      push_word(prrs_pkg::ACT_SCHED, '0, '0, 1'b0, '0);
      push_word(prrs_pkg::ACT_QUERY, 6'd0, 2'd0, 1'b0, 2'd3);
      push_word(prrs_pkg::ACT_QUERY, 6'd63, 2'd3, 1'b1, 2'd0);
      push_word(prrs_pkg::ACT_REMOVE, 6'd21, 2'd0, 1'b0, 2'd0);
      push_word(prrs_pkg::ACT_REMOVE, 6'd63, 2'd0, 1'b0, 2'd0);
      push_word(prrs_pkg::ACT_QUERY, 6'd63, 2'd0, 1'b0, 2'd0);
      push_word(prrs_pkg::ACT_SETPRI, 6'd42, 2'd2, 1'b0, 2'd1);
      push_word(prrs_pkg::ACT_SETPRI, 6'd17, 2'd3, 1'b0, 2'd2);
      push_word(prrs_pkg::ACT_SETRUN, 6'd0, 2'd0, 1'b0, 2'd0);
      push_word(prrs_pkg::ACT_SETRUN, 6'd42, 2'd0, 1'b1, 2'd0);
      push_word(prrs_pkg::ACT_SCHED, '0, '0, 1'b0, '0);
      push_word(ACT_BAD6, 6'd63, 2'd3, 1'b1, 2'd3);
      push_word(ACT_BAD7, 6'd0, 2'd0, 1'b0, 2'd0);
      push_word(prrs_pkg::ACT_QUERY, 6'd42, 2'd0, 1'b0, 2'd2);
      drain();

      push_random(400);
      drain();
      set_slices(8'd0, 8'd0, 8'd0, 8'd0);
      push_random(300);
      drain();
      set_slices(8'($urandom_range(0, 4)), 8'($urandom_range(0, 4)),
                 8'($urandom_range(0, 4)), 8'($urandom_range(0, 4)));
      push_random(300);
      drain();

      // Let one task collect ticks under a large slice, then lower the slice so the count wraps.
      set_slices(8'd255, 8'd255, 8'd255, 8'd255);
      for (int t = 0; t < NTASK; t++)
         push_word(prrs_pkg::ACT_SETRUN, 6'(t), 2'($urandom), 1'b0, 2'($urandom));
      push_word(prrs_pkg::ACT_ADD, 6'd5, 2'd3, 1'b0, 2'd0);
      push_word(prrs_pkg::ACT_SETRUN, 6'd5, 2'd0, 1'b1, 2'd0);
      for (int k = 0; k < 200; k++) push_word(prrs_pkg::ACT_SCHED, '0, '0, 1'b0, '0);
      drain();
      set_slices(8'd0, 8'd0, 8'd0, 8'd0);
      for (int k = 0; k < 70; k++) push_word(prrs_pkg::ACT_SCHED, '0, '0, 1'b0, '0);
      push_word(prrs_pkg::ACT_QUERY, 6'd5, 2'd0, 1'b0, 2'd3);
      push_random(200);
      drain();
      repeat (50) @(posedge clock);
      if (expected_outcomes.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, expected_outcomes.size());
         errors++;
      end

      $display("Ran %0d words through all six actions and bad codes, %0d results checked.",
               words_sent, results_seen);
      $display("Slices swept over reset, zero, small, and 255 values; %0d refusals seen.",
               refusals_seen);
      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
